// File: sv/tcw_pkg.sv
// Shared constants and types for the text console writer.
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVED      = (ROWS - 1) * COLUMNS;  // cells shifted up by a scroll

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int ROW_W  = $clog2(ROWS + 1);         // cursor row may sit at ROWS
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [7:0]  BLANK_CHAR     = 8'h20;
  localparam logic [7:0]  NEWLINE_CHAR   = 8'h0A;
  localparam logic [7:0]  WHITE_ON_BLACK = 8'h0F;
  localparam logic [15:0] CLEAR_CELL     = {WHITE_ON_BLACK, BLANK_CHAR};

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [15:0]       cell_t;

endpackage
`default_nettype wire

// File: sv/tcw_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/text_console_writer_core.sv
// Text console writer: 80 by 25 cell store with cursor, command-style interface.
//
// Usage: drive action, char_code, attribute, row and column and raise start;
// the command is taken at the edge where start is high and busy is low.
// Every command gives exactly one result, shown for one cycle with done high:
// cell_value (read data, zero for all other commands), cursor_row and
// cursor_column (cursor after the command). The receiver cannot stall; the
// result must be taken in its done cycle.
// Sequence, from the accepting edge to the done cycle:
//   put character or newline, write cell : the S_PUT or S_WRITE state
//   read cell                            : S_READ, then S_READ_WAIT (registered RAM read)
//   clear screen                         : an S_CLEAR pass over all CELL_COUNT cells
//   put with scroll pending              : a copy pass (S_SCROLL) through the RAM,
//     then a bottom-row fill (S_FILL), then the put itself.
// The rate is set by the single-port-per-direction cell RAM: one cell read
// and one cell written per cycle. A new command may start in the done cycle.
// Reset: the cursor homes and a clearing pass writes the white-on-black blank
// into all CELL_COUNT (2000) cells; busy stays high until that pass ends.
`default_nettype none
module text_console_writer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  char_code,
  input  wire logic [7:0]  attribute,
  input  wire logic [4:0]  row,
  input  wire logic [6:0]  column,
  output logic             done,
  output logic [15:0]      cell_value,
  output logic [4:0]       cursor_row,
  output logic [6:0]       cursor_column
);

  typedef enum logic [3:0] {
    S_INIT,       // clearing pass after reset
    S_IDLE,
    S_PUT,        // write character or take newline, move cursor
    S_WRITE,
    S_READ,       // issue RAM read
    S_READ_WAIT,  // RAM data back
    S_CLEAR,
    S_SCROLL,     // copy rows up, one cell a cycle
    S_FILL        // blank the freed bottom row
  } state_t;

  state_t state;

  // transfer captured at accept
  tcw_pkg::action_t item_action;
  logic [7:0]       item_char;
  logic [7:0]       item_attr;
  logic [4:0]       item_row;
  logic [6:0]       item_column;

  logic [tcw_pkg::ROW_W-1:0] cur_row;
  logic [tcw_pkg::COL_W-1:0] cur_col;
  tcw_pkg::addr_t            cnt;     // sweep / copy pointer

  logic           ram_we;
  tcw_pkg::addr_t ram_waddr;
  tcw_pkg::cell_t ram_wdata;
  tcw_pkg::addr_t ram_raddr;
  tcw_pkg::cell_t ram_rdata;

  logic           item_in_range;
  tcw_pkg::addr_t item_addr;
  tcw_pkg::addr_t cursor_addr;
  logic           accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign cursor_row    = 5'(cur_row);
  assign cursor_column = 7'(cur_col);

  assign item_in_range = (32'(item_row) < tcw_pkg::ROWS) &&
                         (32'(item_column) < tcw_pkg::COLUMNS);
  // Out-of-range addresses may wrap; those accesses are masked by item_in_range.
  assign item_addr   = tcw_pkg::ADDR_W'(32'(item_row) * tcw_pkg::COLUMNS) +
                       tcw_pkg::ADDR_W'(item_column);
  assign cursor_addr = tcw_pkg::ADDR_W'(32'(cur_row) * tcw_pkg::COLUMNS) +
                       tcw_pkg::ADDR_W'(cur_col);

  // RAM port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = tcw_pkg::CLEAR_CELL;
    ram_raddr = item_addr;
    unique case (state)
      S_INIT, S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = (item_char != tcw_pkg::NEWLINE_CHAR);
        ram_waddr = cursor_addr;
        ram_wdata = {item_attr, item_char};
      end
      S_WRITE: begin
        ram_we    = item_in_range;
        ram_waddr = item_addr;
        ram_wdata = {item_attr, item_char};
      end
      S_SCROLL: begin
        // read one row ahead, write back the cell read in the previous cycle;
        // reads always run ahead of writes, so no overlap on an entry
        ram_raddr = cnt + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        ram_we    = (cnt != '0);
        ram_waddr = cnt - tcw_pkg::ADDR_W'(1);
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {item_attr, tcw_pkg::BLANK_CHAR};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      done       <= 1'b0;
      cell_value <= '0;
    end else begin
      done       <= 1'b0;
      cell_value <= '0;
      unique case (state)
        S_INIT: begin
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_action <= tcw_pkg::action_t'(action);
            item_char   <= char_code;
            item_attr   <= attribute;
            item_row    <= row;
            item_column <= column;
            cnt         <= '0;
            unique case (tcw_pkg::action_t'(action))
              tcw_pkg::ACT_PUT: begin
                if (cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS)) begin
                  state <= S_SCROLL;
                end else begin
                  state <= S_PUT;
                end
              end
              tcw_pkg::ACT_WRITE: state <= S_WRITE;
              tcw_pkg::ACT_READ:  state <= S_READ;
              default:            state <= S_CLEAR;
            endcase
          end
        end
        S_PUT: begin
          if (item_char == tcw_pkg::NEWLINE_CHAR ||
              cur_col == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
            cur_col <= '0;
            cur_row <= cur_row + tcw_pkg::ROW_W'(1);
          end else begin
            cur_col <= cur_col + tcw_pkg::COL_W'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_READ: begin
          state <= S_READ_WAIT;
        end
        S_READ_WAIT: begin
          cell_value <= item_in_range ? ram_rdata : '0;
          done       <= 1'b1;
          state      <= S_IDLE;
        end
        S_CLEAR: begin
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            cnt     <= '0;
            cur_row <= '0;
            cur_col <= '0;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        S_SCROLL: begin
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::MOVED)) begin
            state <= S_FILL;   // last copy written this cycle; fill starts here
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        S_FILL: begin
          if (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1)) begin
            cnt     <= '0;
            cur_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
            state   <= S_PUT;
          end else begin
            cnt <= cnt + tcw_pkg::ADDR_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tcw_ram #(
    .DEPTH (tcw_pkg::CELL_COUNT),
    .WIDTH (16),
    .ADDR_W(tcw_pkg::ADDR_W)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // a result only ever appears with the block ready for the next command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // an accepted command always occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("accepted command did not start");

  // the cursor never passes the scroll-pending row or the last column
  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) <= tcw_pkg::ROWS) && (32'(cur_col) < tcw_pkg::COLUMNS))
    else $error("cursor out of bounds");

  // a read result is non-zero only after a read command
  a_value_read: assert property (@(posedge clk) disable iff (rst)
    (done && cell_value != '0) |-> item_action == tcw_pkg::ACT_READ)
    else $error("cell value on a non-read command");
`endif

endmodule
`default_nettype wire
